/* rtl/pcr_pkg.sv */
// shared types, codes and character tables for the prefixed command recognizer
// no dependencies

package pcr_pkg;

	localparam int unsigned PFX_LEN  = 7;
	localparam int unsigned KW0_LEN  = 12;
	localparam int unsigned KW1_LEN  = 11;
	localparam int unsigned BODY_MAX = 15;

	// phase codes
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_PREFIX_MISMATCH = 2'd0;
	localparam logic [1:0] VERDICT_UNKNOWN         = 2'd1;
	localparam logic [1:0] VERDICT_CANCEL          = 2'd2;
	localparam logic [1:0] VERDICT_RESET           = 2'd3;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;

	typedef struct packed {
		logic [1:0] phase;
		logic [2:0] prefix_position;
		logic [3:0] body_position;
		logic [1:0] keyword_alive;
		logic       blank_pending;
		logic       prefix_failed;
	} pcr_state_t;

	localparam pcr_state_t STATE_RESET = '{
		phase:           PH_SKIP,
		prefix_position: 3'd0,
		body_position:   4'd0,
		keyword_alive:   2'b11,
		blank_pending:   1'b0,
		prefix_failed:   1'b0
	};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

	// prefix text, seven bytes ending in '#'
	function automatic logic [7:0] pfx_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0:    r = 8'h63;
			3'd1:    r = 8'h72;
			3'd2:    r = 8'h61;
			3'd3:    r = 8'h6e;
			3'd4:    r = 8'h65;
			3'd5:    r = 8'h72;
			3'd6:    r = 8'h23;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "AT+OTACANCEL"
	function automatic logic [7:0] kw0_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = 8'h41;
			4'd1:    r = 8'h54;
			4'd2:    r = 8'h2b;
			4'd3:    r = 8'h4f;
			4'd4:    r = 8'h54;
			4'd5:    r = 8'h41;
			4'd6:    r = 8'h43;
			4'd7:    r = 8'h41;
			4'd8:    r = 8'h4e;
			4'd9:    r = 8'h43;
			4'd10:   r = 8'h45;
			4'd11:   r = 8'h4c;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "AT+SYSRESET"
	function automatic logic [7:0] kw1_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0:    r = 8'h41;
			4'd1:    r = 8'h54;
			4'd2:    r = 8'h2b;
			4'd3:    r = 8'h53;
			4'd4:    r = 8'h59;
			4'd5:    r = 8'h53;
			4'd6:    r = 8'h52;
			4'd7:    r = 8'h45;
			4'd8:    r = 8'h53;
			4'd9:    r = 8'h45;
			4'd10:   r = 8'h54;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* rtl/pcr_step.sv */
// next-state and verdict logic for one received byte
// depends on pcr_pkg

module pcr_step
	import pcr_pkg::*;
(
	input  pcr_state_t cur,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output pcr_state_t nxt,
	output logic [1:0] verdict
);

	pcr_state_t upd;
	logic       blank;
	logic       pfx_hit;
	logic       kw0_hit;
	logic       kw1_hit;

	assign blank   = is_blank(data_byte);
	assign pfx_hit = (cur.prefix_position < 3'(PFX_LEN)) &&
		(pfx_char(cur.prefix_position) == data_byte);
	assign kw0_hit = (cur.body_position < 4'(KW0_LEN)) &&
		(kw0_char(cur.body_position) == data_byte);
	assign kw1_hit = (cur.body_position < 4'(KW1_LEN)) &&
		(kw1_char(cur.body_position) == data_byte);

	always_comb begin
		upd = cur;
		if (!cur.prefix_failed) begin
			if (cur.phase == PH_SKIP) begin
				if (!blank) begin
					// first non-blank is also the first prefix byte
					if (pfx_hit) begin
						upd.prefix_position = cur.prefix_position + 3'd1;
						upd.phase = (cur.prefix_position == 3'(PFX_LEN - 1)) ? PH_BODY : PH_PREFIX;
					end else begin
						upd.phase = PH_PREFIX;
						upd.prefix_failed = 1'b1;
					end
				end
			end else if (cur.phase == PH_PREFIX) begin
				if (pfx_hit) begin
					upd.prefix_position = cur.prefix_position + 3'd1;
					if (cur.prefix_position == 3'(PFX_LEN - 1)) begin
						upd.phase = PH_BODY;
					end
				end else begin
					upd.prefix_failed = 1'b1;
				end
			end else begin
				// body, unused code behaves the same
				if (blank) begin
					upd.blank_pending = 1'b1;
				end else if (cur.blank_pending) begin
					upd.keyword_alive = 2'b00;
				end else begin
					upd.keyword_alive = cur.keyword_alive & {kw1_hit, kw0_hit};
					if (cur.body_position < 4'(BODY_MAX)) begin
						upd.body_position = cur.body_position + 4'd1;
					end
				end
			end
		end
	end

	always_comb begin
		priority if (upd.prefix_failed || upd.phase == PH_SKIP || upd.phase == PH_PREFIX) begin
			verdict = VERDICT_PREFIX_MISMATCH;
		end else if (upd.keyword_alive[0] && upd.body_position == 4'(KW0_LEN)) begin
			verdict = VERDICT_CANCEL;
		end else if (upd.keyword_alive[1] && upd.body_position == 4'(KW1_LEN)) begin
			verdict = VERDICT_RESET;
		end else begin
			verdict = VERDICT_UNKNOWN;
		end
	end

	// a line ends in a verdict and a fresh start
	assign nxt = last_byte ? STATE_RESET : upd;

endmodule

/* rtl/prefixed_command_recognizer.sv */
// Prefixed command recognizer top level: input beat register, step logic, verdict register.
// A last beat's verdict is registered in the verdict register, which drives m_tvalid.
// Throughput: one beat per cycle unless a last beat waits for the verdict register;
// the line state loop is a single register with combinational compare logic before it.
// A waiting verdict holds only a last beat in the input register, and the input behind it.
// Reset (arst_n low, asynchronous): pipeline empty, line state back to skipping blanks.

module prefixed_command_recognizer
	import pcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,  // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [1:0] verdict, [7:2] zero
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	pcr_state_t state_q;
	pcr_state_t state_nxt;
	logic [1:0] verdict_c;
	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic       out_free;
	logic       fire_s1;

	assign out_free = !out_valid_q || m_tready;
	// only a last beat needs room in the verdict register
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pcr_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			verdict_q <= verdict_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, verdict_q};

endmodule
